@@ rtl/core/mpsc_pkg.sv @@
package mpsc_pkg;

	localparam int QUERY_W = 12;
	localparam int COUNT_W = 3;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LOOKUP = 4'b0010,
		ST_WRITE  = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

endpackage

@@ rtl/core/mpsc_table.sv @@
module mpsc_table #(
	parameter int DEPTH = 4096
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  logic [mpsc_pkg::COUNT_W-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [$clog2(DEPTH)-1:0]     rd_addr,
	output logic [mpsc_pkg::COUNT_W-1:0] rd_data
);

	logic [mpsc_pkg::COUNT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/min_perfect_square_count.sv @@
// Least number of perfect squares summing to query_value (0 for a zero query;
// queries above MAX_VALUE saturate to it). Every query rebuilds a table of
// best counts for 1..n in an on-chip RAM of MAX_VALUE+1 entries, so the time
// a query of n occupies the block grows with n. The single RAM read port, one
// table read per cycle, bounds how fast the table is built. The block takes
// one query at a time; in_ready is high only when no query is being worked.
// The result sits in an output register, so a new query may be taken while
// the previous result waits. No clearing pass is needed after reset.
module min_perfect_square_count #(
	parameter int MAX_VALUE = 4095
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mpsc_pkg::QUERY_W-1:0] query_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mpsc_pkg::COUNT_W-1:0] square_count
);

	localparam int DEPTH = MAX_VALUE + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = AW + 2;
	localparam int EW    = 17;

	mpsc_pkg::state_t state_q;

	logic [AW-1:0]                n_q;
	logic [AW-1:0]                i_q;
	logic [SW-1:0]                sq_q;
	logic [SW-1:0]                odd_q;
	logic [mpsc_pkg::COUNT_W-1:0] best_q;
	logic                         rd_vld_q;
	logic [mpsc_pkg::COUNT_W-1:0] res_q;
	logic                         out_valid_q;
	logic [mpsc_pkg::COUNT_W-1:0] out_count_q;

	logic [EW-1:0]                q_ext;
	logic [AW-1:0]                n_sat;
	logic                         sq_fits;
	logic [AW-1:0]                rd_addr;
	logic                         rd_en;
	logic [mpsc_pkg::COUNT_W-1:0] rd_data;
	logic [mpsc_pkg::COUNT_W:0]   cand;
	logic [mpsc_pkg::COUNT_W-1:0] best_nxt;
	logic [AW-1:0]                i_nxt;
	logic [mpsc_pkg::COUNT_W-1:0] best_init;
	logic                         wr_en;
	logic                         zero_wr;
	logic [AW-1:0]                wr_addr;
	logic [mpsc_pkg::COUNT_W-1:0] wr_data;
	logic                         out_free;

	assign q_ext = EW'(query_value);
	assign n_sat = (q_ext > EW'(MAX_VALUE)) ? AW'(MAX_VALUE) : AW'(q_ext);

	assign in_ready = state_q == mpsc_pkg::ST_IDLE;
	assign out_free = !out_valid_q || out_ready;

	// inner loop: k*k tracked incrementally, odd_q = 2k+1
	assign sq_fits = sq_q <= SW'(i_q);
	assign rd_en   = (state_q == mpsc_pkg::ST_LOOKUP) && sq_fits;
	assign rd_addr = i_q - AW'(sq_q);

	assign cand     = {1'b0, rd_data} + 1'b1;
	assign best_nxt = (rd_vld_q && (cand < {1'b0, best_q}))
		? mpsc_pkg::COUNT_W'(cand) : best_q;

	assign i_nxt     = i_q + 1'b1;
	assign best_init = ((AW + 3)'(i_nxt) < (AW + 3)'(7))
		? mpsc_pkg::COUNT_W'(i_nxt) : 3'd7;

	// entry 0 is cleared at each accept, ahead of its first read
	assign zero_wr = in_valid && in_ready;
	assign wr_en   = (state_q == mpsc_pkg::ST_WRITE) || zero_wr;
	assign wr_addr = zero_wr ? '0 : i_q;
	assign wr_data = zero_wr ? '0 : best_nxt;

	mpsc_table #(
		.DEPTH (DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mpsc_pkg::ST_IDLE;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= rd_en;
			unique case (state_q)
				mpsc_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= (n_sat == '0) ? mpsc_pkg::ST_DONE : mpsc_pkg::ST_LOOKUP;
					end
				end
				mpsc_pkg::ST_LOOKUP: begin
					if (!sq_fits) begin
						state_q <= mpsc_pkg::ST_WRITE;
					end
				end
				mpsc_pkg::ST_WRITE: begin
					state_q <= (i_q == n_q) ? mpsc_pkg::ST_DONE : mpsc_pkg::ST_LOOKUP;
				end
				mpsc_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= mpsc_pkg::ST_IDLE;
					end
				end
				default: state_q <= mpsc_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mpsc_pkg::ST_IDLE: begin
				n_q    <= n_sat;
				i_q    <= AW'(1);
				sq_q   <= SW'(1);
				odd_q  <= SW'(3);
				best_q <= 3'd1;
				res_q  <= '0;
			end
			mpsc_pkg::ST_LOOKUP: begin
				best_q <= best_nxt;
				if (sq_fits) begin
					sq_q  <= sq_q + odd_q;
					odd_q <= odd_q + SW'(2);
				end
			end
			mpsc_pkg::ST_WRITE: begin
				res_q  <= best_nxt;
				i_q    <= i_nxt;
				sq_q   <= SW'(1);
				odd_q  <= SW'(3);
				best_q <= best_init;
			end
			default: begin
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == mpsc_pkg::ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == mpsc_pkg::ST_DONE) && out_free) begin
			out_count_q <= res_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign square_count = out_count_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("query accepted while previous query still in work");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> square_count <= 3'd4)
		else $error("square count above four");

	a_read_in_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_q |-> (state_q == mpsc_pkg::ST_LOOKUP) || (state_q == mpsc_pkg::ST_WRITE))
		else $error("table read data pending outside entry computation");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpsc_pkg::ST_LOOKUP) |-> (i_q <= n_q) && (i_q != '0))
		else $error("entry index outside 1..n");

endmodule
